FILE: src/qdeq_pkg.sv
// shared types, constants and the quadrature step table of the detent event queue
`default_nettype none

package qdeq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_W   = 8;
  localparam int STAMP_W = 32;
  localparam int LEVEL_W = 2;
  localparam int SUM_W   = 4;

  localparam logic [LEVEL_W-1:0] LEVELS_RESET  = 2'b11;
  localparam logic [KEY_W-1:0]   CW_KEY_RESET  = 8'd0;
  localparam logic [KEY_W-1:0]   CCW_KEY_RESET = 8'd1;

  localparam logic signed [SUM_W-1:0] DETENT_CW  = 4'sd4;
  localparam logic signed [SUM_W-1:0] DETENT_CCW = -4'sd4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_RESYNC = 2'd3
  } op_t;

  typedef enum logic {
    REG_CW_KEY  = 1'b0,
    REG_CCW_KEY = 1'b1
  } reg_idx_t;

  typedef logic signed [1:0] step_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [KEY_W-1:0]   key;
  } rec_t;

  // index is {previous a, previous b, current a, current b}
  function automatic step_t step_lookup(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sb01;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sb11;
      default:                  s = 2'sb00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/quadrature_detent_event_queue.sv
// top level: quadrature decoder, detent detection and event ring with stream and apb ports
// The block takes one item per clock on the s_ stream while the skid stage is empty; tuser
// carries the operation (tick, pin sample, read, resync) and tdata the pin levels. Four
// counted quadrature steps in one direction make a detent that queues a press and a release
// event, stamped with the millisecond count; the pair is dropped if the ring cannot take
// both. A read item returns one result on the m_ stream; other items return nothing. Each
// pair is held as one record in a ring memory with one write and one registered read port.
// An output register plus a one-entry skid stage keep the input open while a result waits,
// so the sustained rate is one item per clock whenever the result side takes one result per
// clock. The ring holds up to QUEUE_DEPTH-1 events. Key codes are written over apb at byte
// addresses 0 (clockwise) and 4 (counterclockwise).
`default_nettype none

module quadrature_detent_event_queue #(
  parameter int QUEUE_DEPTH = qdeq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [1:0] pin_levels, [7:2] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [7:0] key_code, [39:8] stamp_ms
  output logic      [1:0]  m_tuser    // [0] event_valid, [1] event_kind
);

  localparam int CNT_W      = $clog2(QUEUE_DEPTH);
  localparam int REC_W      = CNT_W - 1;
  localparam int REC_DEPTH  = 2 ** REC_W;
  localparam logic [CNT_W:0] PUSH_LIMIT = (CNT_W + 1)'(QUEUE_DEPTH - 2);

  logic [qdeq_pkg::KEY_W-1:0]          cw_key;
  logic [qdeq_pkg::KEY_W-1:0]          ccw_key;
  logic [qdeq_pkg::LEVEL_W-1:0]        last_levels;
  logic [qdeq_pkg::LEVEL_W-1:0]        last_levels_next;
  logic signed [qdeq_pkg::SUM_W-1:0]   step_sum;
  logic signed [qdeq_pkg::SUM_W-1:0]   step_sum_next;
  logic signed [qdeq_pkg::SUM_W-1:0]   sum_add;
  logic signed [qdeq_pkg::SUM_W-1:0]   step_ext;
  logic [qdeq_pkg::STAMP_W-1:0]        ms_counter;
  logic [qdeq_pkg::STAMP_W-1:0]        ms_counter_next;
  logic [CNT_W-1:0]                    evt_count;
  logic [CNT_W-1:0]                    evt_count_next;
  logic [REC_W-1:0]                    rec_wr;
  logic [REC_W-1:0]                    rec_rd;
  logic                                rd_phase;

  qdeq_pkg::rec_t                      rec_mem [REC_DEPTH];
  qdeq_pkg::rec_t                      rec_rdata;
  qdeq_pkg::rec_t                      rec_new;

  logic                                skid_valid;
  logic                                skid_evt;
  logic                                skid_kind;
  logic [REC_W-1:0]                    skid_addr;
  logic                                out_evt;
  logic                                out_kind;

  qdeq_pkg::op_t                       op;
  qdeq_pkg::step_t                     step;
  logic [qdeq_pkg::LEVEL_W-1:0]        pins;
  logic                                accept;
  logic                                is_read;
  logic                                pop;
  logic                                push;
  logic                                detent_cw;
  logic                                detent_ccw;
  logic                                out_load;
  logic                                rd_en;
  logic [REC_W-1:0]                    rd_addr;
  logic                                cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_key  <= qdeq_pkg::CW_KEY_RESET;
      ccw_key <= qdeq_pkg::CCW_KEY_RESET;
    end else if (cfg_wr) begin
      unique case (qdeq_pkg::reg_idx_t'(paddr[2]))
        qdeq_pkg::REG_CW_KEY:  cw_key  <= pwdata[qdeq_pkg::KEY_W-1:0];
        qdeq_pkg::REG_CCW_KEY: ccw_key <= pwdata[qdeq_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (qdeq_pkg::reg_idx_t'(paddr[2]))
      qdeq_pkg::REG_CW_KEY:  prdata = {{(32 - qdeq_pkg::KEY_W){1'b0}}, cw_key};
      qdeq_pkg::REG_CCW_KEY: prdata = {{(32 - qdeq_pkg::KEY_W){1'b0}}, ccw_key};
      default: ;
    endcase
  end

  // input decode and step decode
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign op       = qdeq_pkg::op_t'(s_tuser);
  assign pins     = s_tdata[qdeq_pkg::LEVEL_W-1:0];

  assign step       = qdeq_pkg::step_lookup({last_levels, pins});
  assign step_ext   = {{(qdeq_pkg::SUM_W - 2){step[1]}}, step};
  assign sum_add    = step_sum + step_ext;
  assign detent_cw  = (step != 2'sb00) && (sum_add >= qdeq_pkg::DETENT_CW);
  assign detent_ccw = (step != 2'sb00) && (sum_add <= qdeq_pkg::DETENT_CCW);

  assign is_read = accept && (op == qdeq_pkg::OP_READ);
  assign pop     = is_read && (evt_count != '0);
  assign push    = accept && (op == qdeq_pkg::OP_SAMPLE) && (detent_cw || detent_ccw)
                   && ({1'b0, evt_count} < PUSH_LIMIT);

  assign rec_new.stamp = ms_counter;
  assign rec_new.key   = detent_cw ? cw_key : ccw_key;

  always_comb begin
    last_levels_next = last_levels;
    step_sum_next    = step_sum;
    ms_counter_next  = ms_counter;
    if (accept) begin
      unique case (op)
        qdeq_pkg::OP_TICK: ms_counter_next = ms_counter + 1'b1;
        qdeq_pkg::OP_SAMPLE: begin
          last_levels_next = pins;
          if (detent_cw || detent_ccw) begin
            step_sum_next = '0;
          end else if (step != 2'sb00) begin
            step_sum_next = sum_add;
          end
        end
        qdeq_pkg::OP_READ: ;
        qdeq_pkg::OP_RESYNC: begin
          last_levels_next = pins;
          step_sum_next    = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    evt_count_next = evt_count;
    if (push) begin
      evt_count_next = evt_count + CNT_W'(2);
    end else if (pop) begin
      evt_count_next = evt_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels <= qdeq_pkg::LEVELS_RESET;
      step_sum    <= '0;
      ms_counter  <= '0;
      evt_count   <= '0;
      rec_wr      <= '0;
      rec_rd      <= '0;
      rd_phase    <= 1'b0;
    end else begin
      last_levels <= last_levels_next;
      step_sum    <= step_sum_next;
      ms_counter  <= ms_counter_next;
      evt_count   <= evt_count_next;
      if (push) begin
        rec_wr <= rec_wr + 1'b1;
      end
      if (pop) begin
        rd_phase <= !rd_phase;
        if (rd_phase) begin
          rec_rd <= rec_rd + 1'b1;
        end
      end
    end
  end

  // pair record memory
  assign out_load = !m_tvalid || m_tready;
  assign rd_en    = out_load && (skid_valid || is_read);
  assign rd_addr  = skid_valid ? skid_addr : rec_rd;

  always_ff @(posedge clk) begin
    if (push) begin
      rec_mem[rec_wr] <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rec_rdata <= rec_mem[rd_addr];
    end
  end

  // skid stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid && out_load) begin
      skid_valid <= 1'b0;
    end else if (is_read && !out_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read && !out_load) begin
      skid_evt  <= pop;
      skid_kind <= rd_phase;
      skid_addr <= rec_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= skid_valid || is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_evt  <= skid_evt;
        out_kind <= skid_kind;
      end else if (is_read) begin
        out_evt  <= pop;
        out_kind <= rd_phase;
      end
    end
  end

  assign m_tdata = out_evt ? {rec_rdata.stamp, rec_rdata.key} : '0;
  assign m_tuser = {out_evt && out_kind, out_evt};

endmodule

`default_nettype wire

FILE: src/qdeq_checker.sv
// port-level checker for the detent event queue result stream, with its bind
`default_nettype none

module qdeq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic        evt_xfer;
  logic        prev_kind;
  logic [7:0]  prev_key;
  logic [31:0] prev_stamp;

  assign evt_xfer = m_tvalid && m_tready && m_tuser[0];

  // last event transfer seen
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kind <= 1'b1;
    end else if (evt_xfer) begin
      prev_kind <= m_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (evt_xfer) begin
      prev_key   <= m_tdata[7:0];
      prev_stamp <= m_tdata[39:8];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == 40'd0) && !m_tuser[1])
    else $error("empty read carries nonzero fields");

  a_release_match: assert property (@(posedge clk) disable iff (rst)
    evt_xfer && m_tuser[1] |->
      !prev_kind && (prev_key == m_tdata[7:0]) && (prev_stamp == m_tdata[39:8]))
    else $error("release does not match preceding press");

  a_press_order: assert property (@(posedge clk) disable iff (rst)
    evt_xfer && !m_tuser[1] |-> prev_kind)
    else $error("press follows an unreleased press");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind quadrature_detent_event_queue qdeq_checker u_qdeq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
